// ===== rtl/core/sab_pkg.sv =====
// sab_pkg: shared types and codes of the source address blocklist
// no dependencies; imported by sab_front, sab_back and source_address_blocklist
`default_nettype none

package sab_pkg;

    localparam int ADDR_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_RESET  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic                drop;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/source_address_blocklist.sv =====
// source_address_blocklist: top level, command queue in front of the table sequencer
// depends on sab_pkg, sab_front, sab_back (and sab_ram below it)
`default_nettype none

// channel  | direction | word layout (lsb first)
// s side   | in        | opcode[1:0], addr[33:2], zero pad[39:34]
// m side   | out       | drop[0], status[2:1], count[6:3], zero pad[7]
//
// in the sequencer, a reset, an empty table or an add to a full table goes straight to
// the final state; otherwise the scan reads one table entry per cycle through
// the single ram read port and ends at a hit or after the last valid entry; a successful
// remove then fetches the last entry through the read-last and latch states.
// reset empties the table at once by clearing the entry count; no clearing pass.
// a two-word queue takes input while the sequencer works; the result register
// holds a finished word while the next one is in progress, and the sequencer waits
// in its final cycle while that register is still full.

module source_address_blocklist
    import sab_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // opcode[1:0], addr[33:2]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [7:0]  o_m_tdata    // drop[0], status[2:1], count[6:3]
);

    t_cmd    in_cmd, q_cmd;
    logic    q_valid, q_ready;
    t_result res;

    assign in_cmd.op   = i_s_tdata[OP_W-1:0];
    assign in_cmd.addr = i_s_tdata[OP_W+ADDR_W-1:OP_W];

    sab_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_cmd       (in_cmd),
        .o_cmd_valid (q_valid),
        .o_cmd       (q_cmd),
        .i_cmd_ready (q_ready)
    );

    sab_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_res_valid (o_m_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_tready)
    );

    assign o_m_tdata = {1'b0, res.count, res.status, res.drop};

endmodule

`default_nettype wire

// ===== rtl/core/sab_ram.sv =====
// sab_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/sab_front.sv =====
// sab_front: accepts command words and holds them in a two-entry queue
// depends on sab_pkg
`default_nettype none

module sab_front
    import sab_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_ready
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    logic       push, pop;

    assign o_ready     = (r_fill != 2'd2);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            unique case ({push, pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sab_back.sv =====
// sab_back: table sequencer; scans entries with one comparator, applies updates,
// holds the result register. depends on sab_pkg and sab_ram
`default_nettype none

module sab_back
    import sab_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_ready,
    output logic      o_res_valid,
    output t_result   o_res,
    input  wire logic i_res_ready
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_RDLAST = 3'd2;
    localparam logic [2:0] S_LATCH  = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]        r_state;
    logic [CW-1:0]     r_count;
    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [IW-1:0]     r_idx, r_cidx, r_slot;
    logic              r_dvalid, r_hit;
    logic [ADDR_W-1:0] r_last;
    logic              r_out_valid;
    t_result           r_out;

    logic [CW-1:0]     last_cnt;
    logic [IW-1:0]     rd_addr, wr_addr;
    logic [ADDR_W-1:0] rd_data, wr_data;
    logic              we, out_free, is_full, cmp_hit, cmp_end;
    logic [CW+3:0]     cnt_ext;
    t_result           res;
    logic [CW-1:0]     n_count;

    assign last_cnt = r_count - CW'(1);
    assign is_full  = (r_count >= FULL_CNT);
    assign out_free = !r_out_valid || i_res_ready;
    assign cmp_hit  = r_dvalid && (rd_data == r_addr);
    assign cmp_end  = r_dvalid && (CW'(r_cidx) == last_cnt);

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        rd_addr = r_idx;
        if (r_state == S_RDLAST) begin
            rd_addr = last_cnt[IW-1:0];
        end
    end

    // final update and result, applied when the output register is free
    always_comb begin
        we          = 1'b0;
        wr_addr     = r_count[IW-1:0];
        wr_data     = r_addr;
        n_count     = r_count;
        res.drop    = 1'b0;
        res.status  = ST_OK;
        unique case (r_op)
            OP_LOOKUP: res.drop = r_hit;
            OP_ADD: begin
                if (is_full) begin
                    res.status = ST_FULL;
                end else if (r_hit) begin
                    res.status = ST_PRESENT;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (!r_hit) begin
                    res.status = ST_ABSENT;
                end else begin
                    // last valid entry moves into the freed slot
                    we      = 1'b1;
                    wr_addr = r_slot;
                    wr_data = r_last;
                    n_count = last_cnt;
                end
            end
            default: n_count = '0;
        endcase
        if (r_state != S_FIN || !out_free) begin
            we = 1'b0;
        end
        cnt_ext   = {4'b0000, n_count};
        res.count = cnt_ext[3:0];
    end

    sab_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_dvalid    <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op     <= i_cmd.op;
                        r_addr   <= i_cmd.addr;
                        r_hit    <= 1'b0;
                        r_idx    <= '0;
                        r_dvalid <= 1'b0;
                        if (i_cmd.op == OP_RESET || r_count == '0
                                || (i_cmd.op == OP_ADD && is_full)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (cmp_hit) begin
                        r_hit    <= 1'b1;
                        r_slot   <= r_cidx;
                        r_dvalid <= 1'b0;
                        r_state  <= (r_op == OP_REMOVE) ? S_RDLAST : S_FIN;
                    end else if (cmp_end) begin
                        r_dvalid <= 1'b0;
                        r_state  <= S_FIN;
                    end else begin
                        // one read issued per cycle, compared once the registered read data returns
                        r_dvalid <= 1'b1;
                        r_cidx   <= r_idx;
                        r_idx    <= r_idx + IW'(1);
                    end
                end
                S_RDLAST: r_state <= S_LATCH;
                S_LATCH: begin
                    r_last  <= rd_data;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_count <= n_count;
                        r_out   <= res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
